// File: rtl/xtea_pkg.sv
// Package for the XTEA block cipher: widths, register indexes, state codes,
// the configuration bundle type and the word mixing function. No dependencies.
`default_nettype none

package xtea_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned RoundW  = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned KeyN    = 4;

  localparam logic [WordW-1:0]  Delta        = 32'h9E3779B9;
  localparam logic [RoundW-1:0] RoundsReset  = 8'd32;
  localparam logic [WordW+RoundW-1:0] DecSumResetFull =
    (WordW+RoundW)'(Delta) * (WordW+RoundW)'(RoundsReset);
  localparam logic [WordW-1:0]  DecSumReset  = DecSumResetFull[WordW-1:0];

  // Key index selection for the two half-rounds
  localparam int unsigned KeyHiShift = 11;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY0   = 3'd0,
    REG_KEY1   = 3'd1,
    REG_KEY2   = 3'd2,
    REG_KEY3   = 3'd3,
    REG_ROUNDS = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } seq_state_t;

  typedef logic [KeyN-1:0][WordW-1:0] key_words_t;

  // Configuration as seen by the datapath
  typedef struct packed {
    key_words_t        keys;
    logic [RoundW-1:0] rounds;
    logic [WordW-1:0]  dec_sum;
  } cfg_bundle_t;

  function automatic logic [WordW-1:0] mix_word(input logic [WordW-1:0] w);
    mix_word = ((w << 4) ^ (w >> 5)) + w;
  endfunction

endpackage

`default_nettype wire

// File: rtl/xtea_block_cipher_top.sv
// XTEA block cipher, one 64-bit block per transaction (ECB).
// One half-round of the shared round unit runs per cycle while a block is in
// flight. A new block is taken only once the last one has moved to the output
// register; a finished result waits in the output register while the next
// block is taken.
// Reset (rst_n low, synchronous): keys clear to zero, round_count to 32, idle.
`default_nettype none

module xtea_block_cipher_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [xtea_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [xtea_pkg::WordW-1:0]   cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_op,
  input  wire logic [xtea_pkg::WordW-1:0]   in_word_first,
  input  wire logic [xtea_pkg::WordW-1:0]   in_word_second,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [xtea_pkg::WordW-1:0]   out_out_first,
  output logic      [xtea_pkg::WordW-1:0]   out_out_second
);
  import xtea_pkg::*;

  cfg_bundle_t cfg;

  // Register writes are taken in any cycle
  assign cfg_ready = 1'b1;

  xtea_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  xtea_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_word_first  (in_word_first),
    .in_word_second (in_word_second),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_first      (out_out_first),
    .out_second     (out_out_second)
  );

endmodule

`default_nettype wire

// File: rtl/xtea_cfg.sv
// Configuration register file: four key words and the round count.
// Also keeps the decryption start sum (delta times rounds). Uses xtea_pkg.
`default_nettype none

module xtea_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         wr_en,
  input  wire logic [xtea_pkg::CfgIdxW-1:0] wr_idx,
  input  wire logic [xtea_pkg::WordW-1:0]   wr_data,
  output xtea_pkg::cfg_bundle_t             cfg
);
  import xtea_pkg::*;

  key_words_t        key_r;
  logic [RoundW-1:0] rounds_r;
  logic [WordW-1:0]  dec_sum_r;
  logic [WordW+RoundW-1:0] dec_sum_full;

  // Start sum for decryption, registered along with the round count
  assign dec_sum_full = (WordW+RoundW)'(Delta) * (WordW+RoundW)'(wr_data[RoundW-1:0]);

  // Write one register per transaction; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r     <= '0;
      rounds_r  <= RoundsReset;
      dec_sum_r <= DecSumReset;
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_idx))
        REG_KEY0:   key_r[0] <= wr_data;
        REG_KEY1:   key_r[1] <= wr_data;
        REG_KEY2:   key_r[2] <= wr_data;
        REG_KEY3:   key_r[3] <= wr_data;
        REG_ROUNDS: begin
          rounds_r  <= wr_data[RoundW-1:0];
          dec_sum_r <= dec_sum_full[WordW-1:0];
        end
        default: ;
      endcase
    end
  end

  assign cfg.keys    = key_r;
  assign cfg.rounds  = rounds_r;
  assign cfg.dec_sum = dec_sum_r;

endmodule

`default_nettype wire

// File: rtl/xtea_round.sv
// Shared XTEA half-round unit: mixes one word, adds the keyed sum and
// updates the other word, for either direction. Uses xtea_pkg.
`default_nettype none

module xtea_round (
  input  wire logic                       dec,
  input  wire logic                       phase,
  input  wire logic [xtea_pkg::WordW-1:0] x,
  input  wire logic [xtea_pkg::WordW-1:0] y,
  input  wire logic [xtea_pkg::WordW-1:0] sum,
  input  wire xtea_pkg::key_words_t       keys,
  output logic      [xtea_pkg::WordW-1:0] x_out,
  output logic      [xtea_pkg::WordW-1:0] y_out
);
  import xtea_pkg::*;

  logic             src_is_x;
  logic [1:0]       key_sel;
  logic [WordW-1:0] src;
  logic [WordW-1:0] dst;
  logic [WordW-1:0] term;
  logic [WordW-1:0] dst_new;

  // Encrypt phase 0 and decrypt phase 1 update x from y with the low key
  // index; the other two update y from x with the index at bit 11
  assign src_is_x = dec ^ phase;
  assign key_sel  = src_is_x ? sum[KeyHiShift +: 2] : sum[1:0];
  assign src      = src_is_x ? x : y;
  assign dst      = src_is_x ? y : x;
  assign term     = mix_word(src) ^ (sum + keys[key_sel]);
  assign dst_new  = dec ? (dst - term) : (dst + term);

  assign x_out = src_is_x ? x : dst_new;
  assign y_out = src_is_x ? dst_new : y;

endmodule

`default_nettype wire

// File: rtl/xtea_core.sv
// Round sequencer: loads a block, runs the shared half-round unit twice per
// cycle of the cipher and hands the pair to the output register.
// Uses xtea_pkg and xtea_round.
`default_nettype none

module xtea_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire xtea_pkg::cfg_bundle_t      cfg,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       in_op,
  input  wire logic [xtea_pkg::WordW-1:0] in_word_first,
  input  wire logic [xtea_pkg::WordW-1:0] in_word_second,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic      [xtea_pkg::WordW-1:0] out_first,
  output logic      [xtea_pkg::WordW-1:0] out_second
);
  import xtea_pkg::*;

  seq_state_t        state_r, state_nxt;
  logic [WordW-1:0]  x_r, x_nxt;
  logic [WordW-1:0]  y_r, y_nxt;
  logic [WordW-1:0]  sum_r, sum_nxt;
  logic [RoundW-1:0] cnt_r, cnt_nxt;
  logic              phase_r, phase_nxt;
  logic              op_r, op_nxt;
  logic              oval_r, oval_nxt;
  logic [WordW-1:0]  ofirst_r, ofirst_nxt;
  logic [WordW-1:0]  osecond_r, osecond_nxt;
  logic [WordW-1:0]  rx, ry;
  logic              in_take;
  logic              out_free;

  xtea_round u_round (
    .dec   (op_r),
    .phase (phase_r),
    .x     (x_r),
    .y     (y_r),
    .sum   (sum_r),
    .keys  (cfg.keys),
    .x_out (rx),
    .y_out (ry)
  );

  assign in_take  = in_valid && (state_r == ST_IDLE);
  assign out_free = !oval_r || !out_stall;

  // Sequencer: next state, datapath and output register
  always_comb begin
    state_nxt   = state_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    sum_nxt     = sum_r;
    cnt_nxt     = cnt_r;
    phase_nxt   = phase_r;
    op_nxt      = op_r;
    oval_nxt    = oval_r && out_stall;
    ofirst_nxt  = ofirst_r;
    osecond_nxt = osecond_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          x_nxt     = in_word_first;
          y_nxt     = in_word_second;
          op_nxt    = in_op;
          sum_nxt   = in_op ? cfg.dec_sum : '0;
          cnt_nxt   = cfg.rounds;
          phase_nxt = 1'b0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt_r == '0) begin
          // hold the result until the output register frees up
          if (out_free) begin
            oval_nxt    = 1'b1;
            ofirst_nxt  = x_r;
            osecond_nxt = y_r;
            state_nxt   = ST_IDLE;
          end
        end else begin
          x_nxt     = rx;
          y_nxt     = ry;
          phase_nxt = !phase_r;
          if (!phase_r) begin
            sum_nxt = op_r ? (sum_r - Delta) : (sum_r + Delta);
          end else begin
            cnt_nxt = cnt_r - 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      oval_r  <= oval_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    sum_r     <= sum_nxt;
    cnt_r     <= cnt_nxt;
    phase_r   <= phase_nxt;
    op_r      <= op_nxt;
    ofirst_r  <= ofirst_nxt;
    osecond_r <= osecond_nxt;
  end

  assign in_stall   = (state_r != ST_IDLE);
  assign out_valid  = oval_r;
  assign out_first  = ofirst_r;
  assign out_second = osecond_r;

endmodule

`default_nettype wire

// File: rtl/xtea_checker.sv
// Port-level checker for the XTEA block cipher top level, bound to it below.
// Uses xtea_pkg for widths.
`default_nettype none

module xtea_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         cfg_ready,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic [xtea_pkg::WordW-1:0]   out_out_first,
  input wire logic [xtea_pkg::WordW-1:0]   out_out_second
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_out_first)
                               && $stable(out_out_second))
    else $error("stalled result changed");

  // Go busy after taking a block
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block taken while not going busy");

  // A new result only appears at the end of a busy period
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a block in flight");

  // Register writes never wait
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind xtea_block_cipher_top xtea_checker u_xtea_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .cfg_ready      (cfg_ready),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_out_first  (out_out_first),
  .out_out_second (out_out_second)
);

`default_nettype wire

// File: bench/xtea_result_checker.sv
// Result checker for the XTEA block cipher: tracks the register writes, predicts
// each block's encrypted or decrypted pair and compares it with the result channel.
// Depends on xtea_pkg for the word width and the register index names.
`timescale 1ns / 100ps

module xtea_result_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [xtea_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [xtea_pkg::WordW-1:0]     cfg_data,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic                           in_op,
  input  logic [xtea_pkg::WordW-1:0]     in_word_first,
  input  logic [xtea_pkg::WordW-1:0]     in_word_second,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [xtea_pkg::WordW-1:0]     out_out_first,
  input  logic [xtea_pkg::WordW-1:0]     out_out_second,
  output int                             error_count,
  output int                             pending_count,
  output int                             blocks_checked
);
  import xtea_pkg::*;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    word_t first;
    word_t second;
  } cipher_block_t;

  localparam word_t XteaDelta = 32'h9E3779B9;

  word_t         key_words [KeyN];
  logic [7:0]    round_count;
  cipher_block_t expected_blocks [$];
  cipher_block_t want;

  // Shift-xor-add mix applied to one half before it meets the key schedule
  function automatic word_t feistel_mix(input word_t w);
    return ((w << 4) ^ (w >> 5)) + w;
  endfunction

  // Run round_count full cycles in the given direction under the current key
  function automatic cipher_block_t xtea_rounds(input logic decrypt, input word_t a,
                                                input word_t b);
    word_t         x;
    word_t         y;
    word_t         sum;
    cipher_block_t res;
    x = a;
    y = b;
    if (decrypt) begin
      sum = XteaDelta * word_t'(round_count);
      for (int r = 0; r < round_count; r++) begin
        y = y - (feistel_mix(x) ^ (sum + key_words[sum[12:11]]));
        sum = sum - XteaDelta;
        x = x - (feistel_mix(y) ^ (sum + key_words[sum[1:0]]));
      end
    end else begin
      sum = '0;
      for (int r = 0; r < round_count; r++) begin
        x = x + (feistel_mix(y) ^ (sum + key_words[sum[1:0]]));
        sum = sum + XteaDelta;
        y = y + (feistel_mix(x) ^ (sum + key_words[sum[12:11]]));
      end
    end
    res.first  = x;
    res.second = y;
    return res;
  endfunction

  initial begin
    error_count    = 0;
    pending_count  = 0;
    blocks_checked = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < KeyN; k++) key_words[k] = '0;
      round_count = RoundsReset;
      expected_blocks.delete();
    end else begin
      // Track register writes; unknown indexes leave everything as it was
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_words[cfg_index[1:0]] = cfg_data;
          REG_ROUNDS: round_count = cfg_data[7:0];
          default: ;
        endcase
      end
      // Compare a finished block against the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_blocks.size() == 0) begin
          $error("result transaction with no block outstanding: %h %h",
                 out_out_first, out_out_second);
          error_count++;
        end else begin
          want = expected_blocks.pop_front();
          blocks_checked++;
          if (out_out_first !== want.first) begin
            $error("out_first: expected %h, got %h", want.first, out_out_first);
            error_count++;
          end
          if (out_out_second !== want.second) begin
            $error("out_second: expected %h, got %h", want.second, out_out_second);
            error_count++;
          end
        end
      end
      // Predict every accepted block
      if (in_valid && !in_stall)
        expected_blocks.push_back(xtea_rounds(in_op, in_word_first, in_word_second));
    end
    pending_count = expected_blocks.size();
  end

endmodule

// File: bench/tb.sv
// Top of the XTEA block cipher bench: clock, reset, block and register stimulus.
// Instantiates xtea_block_cipher_top and xtea_result_checker; uses xtea_pkg names.
`timescale 1ns / 100ps

module tb;
  import xtea_pkg::*;

  localparam int MaxRounds   = 255;
  localparam int RandomItems = 580;

  logic               clk;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [WordW-1:0]   cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic               in_op;
  logic [WordW-1:0]   in_word_first;
  logic [WordW-1:0]   in_word_second;
  logic               out_valid;
  logic               out_stall;
  logic [WordW-1:0]   out_out_first;
  logic [WordW-1:0]   out_out_second;

  int   error_count;
  int   pending_count;
  int   blocks_checked;
  int   blocks_sent;
  int   settings_used;
  int   stall_hold;
  logic jitter_on;

  xtea_block_cipher_top uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_word_first  (in_word_first),
    .in_word_second (in_word_second),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_out_first  (out_out_first),
    .out_out_second (out_out_second)
  );

  xtea_result_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_word_first  (in_word_first),
    .in_word_second (in_word_second),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_out_first  (out_out_first),
    .out_out_second (out_out_second),
    .error_count    (error_count),
    .pending_count  (pending_count),
    .blocks_checked (blocks_checked)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Worst case is about 600 blocks at 255 rounds with full stalls and gaps,
  // roughly 3.3 ms; allow several times that
  initial begin
    #15_000_000;
    $display("simulation failed");
    $finish;
  end

  // Result side backpressure: random stall bursts
  initial begin
    out_stall  = 1'b0;
    stall_hold = 0;
    forever begin
      @(negedge clk);
      if (stall_hold > 0) begin
        stall_hold--;
        out_stall <= 1'b1;
      end else if (jitter_on && $urandom_range(0, 5) == 0) begin
        stall_hold = $urandom_range(1, 6) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Write one register; the block is idle whenever this is called
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [WordW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_key(input logic [WordW-1:0] k0, input logic [WordW-1:0] k1,
                          input logic [WordW-1:0] k2, input logic [WordW-1:0] k3);
    write_reg(REG_KEY0, k0);
    write_reg(REG_KEY1, k1);
    write_reg(REG_KEY2, k2);
    write_reg(REG_KEY3, k3);
    settings_used++;
  endtask

  // Offer one block, optionally after a short gap, and hold it until taken
  task automatic send_block(input logic op, input logic [WordW-1:0] a,
                            input logic [WordW-1:0] b);
    if (jitter_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_op          <= op;
    in_word_first  <= a;
    in_word_second <= b;
    do @(posedge clk); while (in_stall);
    blocks_sent++;
  endtask

  // Stop offering blocks and hold until every predicted result has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  // Random words half the time, else zeros, all ones, single-bit and single-zero patterns
  function automatic logic [WordW-1:0] pick_word();
    logic [WordW-1:0] bit_mask;
    bit_mask = 32'h1 << $urandom_range(0, WordW - 1);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return bit_mask;
      3:       return ~bit_mask;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int          phase_items;
    int          pick;
    logic [7:0]  rounds;

    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_op          = 1'b0;
    in_word_first  = '0;
    in_word_second = '0;
    jitter_on      = 1'b1;
    blocks_sent    = 0;
    settings_used  = 1;

    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Reset key of all zeros and 32 rounds
    send_block(1'b0, '0, '0);
    send_block(1'b0, '1, '1);
    send_block(1'b1, '0, '0);
    send_block(1'b1, '1, '1);
    send_block(1'b0, 32'h8000_0000, 32'h0000_0001);
    wait_drained();

    // Byte-sequence key, round count written with junk above the low byte
    load_key(32'h0302_0100, 32'h0706_0504, 32'h0B0A_0908, 32'h0F0E_0D0C);
    write_reg(REG_ROUNDS, 32'hFFFF_FF20);
    send_block(1'b0, 32'h4443_4241, 32'h4847_4645);
    send_block(1'b1, 32'h4443_4241, 32'h4847_4645);
    send_block(1'b1, $urandom, $urandom);
    send_block(1'b0, $urandom, $urandom);
    wait_drained();

    // Zero rounds pass the block through; unknown indexes must not disturb the key
    write_reg(REG_ROUNDS, 32'h0000_0100);
    for (int idx = REG_ROUNDS + 1; idx < 2 ** CfgIdxW; idx++)
      write_reg(CfgIdxW'(idx), '1);
    send_block(1'b0, 32'hDEAD_BEEF, 32'h0123_4567);
    send_block(1'b1, 32'hDEAD_BEEF, 32'h0123_4567);
    send_block(1'b0, '1, '0);
    send_block(1'b1, '0, '1);
    wait_drained();

    // Longest round count with an all-ones key
    load_key('1, '1, '1, '1);
    write_reg(REG_ROUNDS, MaxRounds);
    send_block(1'b0, '0, '0);
    send_block(1'b1, '1, '1);
    send_block(1'b0, '1, '0);
    send_block(1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
    wait_drained();

    // Single round, zero key
    load_key('0, '0, '0, '0);
    write_reg(REG_ROUNDS, 32'h0000_0001);
    send_block(1'b0, 32'h0000_0001, 32'h8000_0000);
    send_block(1'b1, 32'h0000_0001, 32'h8000_0000);
    wait_drained();

    // Random settings, each followed by a run of random blocks
    while (blocks_sent < RandomItems + 19) begin
      wait_drained();
      for (int idx = 0; idx < 2 ** CfgIdxW; idx++) begin
        if (idx != REG_ROUNDS && $urandom_range(0, 1) == 1)
          write_reg(CfgIdxW'(idx), pick_word());
      end
      pick = $urandom_range(0, 99);
      if (pick < 55)       rounds = 8'($urandom_range(0, 8));
      else if (pick < 85)  rounds = 8'($urandom_range(9, 40));
      else if (pick < 95)  rounds = 8'($urandom_range(41, MaxRounds - 1));
      else                 rounds = 8'(MaxRounds);
      write_reg(REG_ROUNDS, {24'($urandom_range(0, 2 ** 24 - 1)), rounds});
      settings_used++;
      phase_items = (rounds > 40) ? $urandom_range(2, 6) : $urandom_range(10, 40);
      jitter_on   = (blocks_sent < RandomItems - 80) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < phase_items; n++)
        send_block(1'($urandom_range(0, 1)), pick_word(), pick_word());
    end

    // Let the last block clear the round unit
    wait_drained();
    repeat (2 * MaxRounds + 8) @(negedge clk);

    $display("Sent %0d blocks in both directions under %0d key and round settings,",
             blocks_sent, settings_used);
    $display("rounds from 0 to %0d; %0d results compared.", MaxRounds, blocks_checked);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
